// ----- rtl/core/fef_pkg.sv -----
package fef_pkg;

   // Defaults for the top-level parameters
   localparam int FEF_MAX_FRAME_LENGTH = 127;
   localparam int FEF_MAX_PREAMBLE     = 16;
   localparam int FEF_QUEUE_DEPTH      = 4;

   // Smallest valid length byte: a frame with an empty payload still carries the FCS
   localparam logic [7:0] FEF_MIN_FRAME_LENGTH = 8'd2;
   localparam int         FEF_FCS_LENGTH       = 2;

   localparam int FEF_BYTE_WIDTH = 8;
   localparam int FEF_PRE_WIDTH  = 5;
   localparam int FEF_CNT_WIDTH  = 6;
   localparam int FEF_LEFT_WIDTH = 7;
   localparam int FEF_FCS_WIDTH  = 16;
   localparam int FEF_CSR_WIDTH  = 8;
   localparam int FEF_IDX_WIDTH  = 2;

   // Reflected CRC-16 polynomial of the 802.15.4 FCS
   localparam logic [FEF_FCS_WIDTH-1:0] FEF_FCS_POLY = 16'h8408;

   // Register indexes of the configuration port
   localparam logic [FEF_IDX_WIDTH-1:0] CSR_PREAMBLE_LENGTH = 2'd0;
   localparam logic [FEF_IDX_WIDTH-1:0] CSR_PREAMBLE_VALUE  = 2'd1;
   localparam logic [FEF_IDX_WIDTH-1:0] CSR_START_DELIMITER = 2'd2;

   localparam logic [FEF_PRE_WIDTH-1:0]  CSR_PREAMBLE_LENGTH_RESET = 5'd4;
   localparam logic [FEF_BYTE_WIDTH-1:0] CSR_PREAMBLE_VALUE_RESET  = 8'h00;
   localparam logic [FEF_BYTE_WIDTH-1:0] CSR_START_DELIMITER_RESET = 8'hA7;

   typedef enum logic [1:0] {
      CMD_DROP,
      CMD_HEADER,
      CMD_PAYLOAD
   } cmd_kind_type;

   // One classified transaction handed from the front to the back
   typedef struct packed {
      cmd_kind_type                kind;
      logic [FEF_BYTE_WIDTH-1:0]   data;
      logic                        with_fcs;
      logic [FEF_FCS_WIDTH-1:0]    fcs;
   } cmd_type;

   typedef struct packed {
      logic [FEF_PRE_WIDTH-1:0]  preamble_length;
      logic [FEF_BYTE_WIDTH-1:0] preamble_value;
      logic [FEF_BYTE_WIDTH-1:0] start_delimiter;
   } cfg_type;

endpackage

// ----- rtl/core/fef_front.sv -----
module fef_front
   import fef_pkg::*;
#(
   parameter int MAX_FRAME_LENGTH = FEF_MAX_FRAME_LENGTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept_i,
   input  logic [FEF_BYTE_WIDTH-1:0] data_byte_i,
   input  logic                      frame_start_i,
   output logic                      cmd_push_o,
   output cmd_type                   cmd_o
);

   logic                      in_payload_ff, in_payload_in;
   logic [FEF_LEFT_WIDTH-1:0] bytes_left_ff, bytes_left_in;
   logic [FEF_FCS_WIDTH-1:0]  fcs_ff, fcs_in;
   logic [FEF_FCS_WIDTH-1:0]  fcs_folded;
   logic [FEF_LEFT_WIDTH-1:0] left_dec;
   logic                      bad_length;

   function automatic logic [FEF_FCS_WIDTH-1:0] fold_byte(
      input logic [FEF_FCS_WIDTH-1:0]  crc_i,
      input logic [FEF_BYTE_WIDTH-1:0] b_i
   );
      logic [FEF_FCS_WIDTH-1:0] crc;
      crc = crc_i ^ {{(FEF_FCS_WIDTH-FEF_BYTE_WIDTH){1'b0}}, b_i};
      for (int i = 0; i < FEF_BYTE_WIDTH; i++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ FEF_FCS_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

   assign fcs_folded = fold_byte(fcs_ff, data_byte_i);
   assign left_dec   = bytes_left_ff - 1'b1;
   assign bad_length = (data_byte_i < FEF_MIN_FRAME_LENGTH) ||
                       (data_byte_i > FEF_BYTE_WIDTH'(MAX_FRAME_LENGTH));

   always_comb begin
      in_payload_in = in_payload_ff;
      bytes_left_in = bytes_left_ff;
      fcs_in        = fcs_ff;
      cmd_push_o    = 1'b0;
      cmd_o.kind    = CMD_DROP;
      cmd_o.data    = data_byte_i;
      cmd_o.with_fcs = 1'b0;
      cmd_o.fcs     = '0;
      if (accept_i) begin
         if (frame_start_i) begin
            cmd_push_o = 1'b1;
            fcs_in     = '0;
            if (bad_length) begin
               in_payload_in = 1'b0;
               bytes_left_in = '0;
               cmd_o.kind    = CMD_DROP;
            end else begin
               // Empty payload closes the frame right after the length byte
               bytes_left_in  = FEF_LEFT_WIDTH'(data_byte_i - FEF_MIN_FRAME_LENGTH);
               in_payload_in  = (data_byte_i != FEF_MIN_FRAME_LENGTH);
               cmd_o.kind     = CMD_HEADER;
               cmd_o.with_fcs = (data_byte_i == FEF_MIN_FRAME_LENGTH);
            end
         end else if (in_payload_ff) begin
            cmd_push_o     = 1'b1;
            fcs_in         = fcs_folded;
            bytes_left_in  = left_dec;
            in_payload_in  = (left_dec != '0);
            cmd_o.kind     = CMD_PAYLOAD;
            cmd_o.with_fcs = (left_dec == '0);
            cmd_o.fcs      = fcs_folded;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff <= 1'b0;
         bytes_left_ff <= '0;
         fcs_ff        <= '0;
      end else begin
         in_payload_ff <= in_payload_in;
         bytes_left_ff <= bytes_left_in;
         fcs_ff        <= fcs_in;
      end
   end

   // An open frame always has at least one payload byte to go
   assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (bytes_left_ff != '0))
      else $error("open frame with no bytes left");

   assert property (@(posedge clock) disable iff (reset)
      (cmd_push_o && cmd_o.with_fcs) |=> !in_payload_ff)
      else $error("frame still open after its FCS was scheduled");

   assert property (@(posedge clock) disable iff (reset)
      (accept_i && frame_start_i) |-> cmd_push_o)
      else $error("frame start produced no command");

endmodule

// ----- rtl/core/fef_queue.sv -----
module fef_queue
   import fef_pkg::*;
#(
   parameter int DEPTH = FEF_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_i,
   input  cmd_type data_i,
   output logic    full_o,
   input  logic    pop_i,
   output logic    empty_o,
   output cmd_type head_o
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   cmd_type                entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full_o  = (count_ff == CNT_WIDTH'(DEPTH));
   assign empty_o = (count_ff == '0);
   assign head_o  = entry_ff[rd_ptr_ff];
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && !empty_o;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= data_i;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> !empty_o)
      else $error("queue empty after a write");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNT_WIDTH'(DEPTH)))
      else $error("queue count overflow");

   assert property (@(posedge clock) disable iff (reset)
      empty_o |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with split pointers");

endmodule

// ----- rtl/core/fef_back.sv -----
module fef_back
   import fef_pkg::*;
#(
   parameter int MAX_PREAMBLE = FEF_MAX_PREAMBLE
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg_i,
   input  logic                      empty_i,
   input  cmd_type                   head_i,
   output logic                      deq_o,
   output logic                      rsp_empty_o,
   input  logic                      rsp_pop_i,
   output logic [FEF_BYTE_WIDTH-1:0] rsp_out_byte_o,
   output logic                      rsp_dropped_o,
   output logic                      rsp_run_last_o,
   output logic                      rsp_frame_end_o
);

   typedef enum logic [2:0] {
      PH_DROP,
      PH_PRE,
      PH_SFD,
      PH_PHR,
      PH_DATA,
      PH_FCS_LO,
      PH_FCS_HI
   } phase_type;

   logic                      busy_ff, busy_in;
   phase_type                 phase_ff, phase_in;
   logic [FEF_CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   cmd_type                   cmd_ff, cmd_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [FEF_BYTE_WIDTH-1:0] out_byte_ff, out_byte_in;
   logic                      dropped_ff, dropped_in;
   logic                      run_last_ff, run_last_in;
   logic                      frame_end_ff, frame_end_in;

   phase_type                 start_phase, cur_phase;
   logic [FEF_CNT_WIDTH-1:0]  sat_cnt, cur_cnt;
   logic [FEF_CNT_WIDTH-1:0]  pre_len;
   cmd_type                   cur_cmd;
   logic                      advance, step, done;

   // Clamp the preamble count
   assign pre_len = {1'b0, cfg_i.preamble_length};
   assign sat_cnt = (pre_len > FEF_CNT_WIDTH'(MAX_PREAMBLE)) ?
                    FEF_CNT_WIDTH'(MAX_PREAMBLE) : pre_len;

   always_comb begin
      unique case (head_i.kind)
         CMD_DROP:    start_phase = PH_DROP;
         CMD_HEADER:  start_phase = (sat_cnt != '0) ? PH_PRE : PH_SFD;
         CMD_PAYLOAD: start_phase = PH_DATA;
         default:     start_phase = PH_DROP;
      endcase
   end

   assign cur_cmd   = busy_ff ? cmd_ff : head_i;
   assign cur_phase = busy_ff ? phase_ff : start_phase;
   assign cur_cnt   = busy_ff ? cnt_ff : sat_cnt;
   assign advance   = !rsp_valid_ff || rsp_pop_i;
   assign step      = advance && (busy_ff || !empty_i);
   assign deq_o     = step && !busy_ff;

   always_comb begin
      out_byte_in  = cur_cmd.data;
      dropped_in   = 1'b0;
      frame_end_in = 1'b0;
      done         = 1'b1;
      phase_in     = cur_phase;
      cnt_in       = cur_cnt;
      unique case (cur_phase) inside
         PH_DROP: begin
            out_byte_in = '0;
            dropped_in  = 1'b1;
         end
         PH_PRE: begin
            out_byte_in = cfg_i.preamble_value;
            cnt_in      = cur_cnt - 1'b1;
            done        = 1'b0;
            if (cnt_in == '0) begin
               phase_in = PH_SFD;
            end
         end
         PH_SFD: begin
            out_byte_in = cfg_i.start_delimiter;
            done        = 1'b0;
            phase_in    = PH_PHR;
         end
         PH_PHR, PH_DATA: begin
            done     = !cur_cmd.with_fcs;
            phase_in = PH_FCS_LO;
         end
         PH_FCS_LO: begin
            out_byte_in = cur_cmd.fcs[FEF_BYTE_WIDTH-1:0];
            done        = 1'b0;
            phase_in    = PH_FCS_HI;
         end
         PH_FCS_HI: begin
            out_byte_in  = cur_cmd.fcs[FEF_FCS_WIDTH-1:FEF_BYTE_WIDTH];
            frame_end_in = 1'b1;
         end
         default: begin
            out_byte_in = '0;
         end
      endcase
      run_last_in  = done;
      busy_in      = step ? !done : busy_ff;
      cmd_in       = cur_cmd;
      rsp_valid_in = step ? 1'b1 : (advance ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PH_DROP;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            phase_ff <= phase_in;
         end
      end
      if (step) begin
         cnt_ff       <= cnt_in;
         cmd_ff       <= cmd_in;
         out_byte_ff  <= out_byte_in;
         dropped_ff   <= dropped_in;
         run_last_ff  <= run_last_in;
         frame_end_ff <= frame_end_in;
      end
   end

   assign rsp_empty_o     = !rsp_valid_ff;
   assign rsp_out_byte_o  = out_byte_ff;
   assign rsp_dropped_o   = dropped_ff;
   assign rsp_run_last_o  = run_last_ff;
   assign rsp_frame_end_o = frame_end_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && frame_end_ff) |-> (run_last_ff && !dropped_ff))
      else $error("frame end on a result that is not the last of its transaction");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && dropped_ff) |-> (run_last_ff && out_byte_ff == '0))
      else $error("dropped result carries data or is not final");

   assert property (@(posedge clock) disable iff (reset)
      deq_o |-> (!busy_ff && !empty_i))
      else $error("command taken while still expanding the previous one");

   assert property (@(posedge clock) disable iff (reset)
      (step && !done) |=> (busy_ff && !rsp_empty_o))
      else $error("unfinished command lost its expansion");

endmodule

// ----- rtl/core/ieee802154_frame_emitter.sv -----
// IEEE 802.15.4 PHY frame emitter with FCS generation.
//
// Input channel (push / full): one frame buffer byte per transaction, the
// length byte (PHR) first with req_frame_start high. Result channel
// (empty / pop): one on-air byte per transaction with its flags.
// Configuration: csr_write_enable writes csr_write_data into the register
// named by csr_index (0 preamble length, 1 preamble value, 2 start
// delimiter); write only while the block is idle.
//
// The front classifies each byte and folds payload bytes into the CRC-16,
// a command queue of QUEUE_DEPTH entries follows, and the back expands each
// command into result bytes, one per cycle while the receiver keeps popping.
// The first result of a transaction passes through the queue and the back's
// output register. A payload byte yields one result (three when it closes the
// frame); a length byte yields the clamped preamble length plus two (plus two
// more for an empty payload). The output register sets the sustained rate.
//
// Reset clears the frame state, the queue and the output valid flag and
// loads the register defaults. When the receiver holds off pop, the output
// register holds, the back stalls, the queue fills, and full rises.
module ieee802154_frame_emitter
   import fef_pkg::*;
#(
   parameter int MAX_FRAME_LENGTH = FEF_MAX_FRAME_LENGTH,
   parameter int MAX_PREAMBLE     = FEF_MAX_PREAMBLE,
   parameter int QUEUE_DEPTH      = FEF_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   // input channel
   input  logic                      push,
   output logic                      full,
   input  logic [FEF_BYTE_WIDTH-1:0] req_data_byte,
   input  logic                      req_frame_start,
   // result channel
   output logic                      empty,
   input  logic                      pop,
   output logic [FEF_BYTE_WIDTH-1:0] rsp_out_byte,
   output logic                      rsp_dropped,
   output logic                      rsp_run_last,
   output logic                      rsp_frame_end,
   // configuration port
   input  logic                      csr_write_enable,
   input  logic [FEF_IDX_WIDTH-1:0]  csr_index,
   input  logic [FEF_CSR_WIDTH-1:0]  csr_write_data
);

   cfg_type cfg_ff, cfg_in;
   logic    accept;
   logic    cmd_push;
   cmd_type cmd;
   logic    q_full, q_empty, q_deq;
   cmd_type q_head;

   // Hold the configuration; index 3 writes nothing
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PREAMBLE_LENGTH: cfg_in.preamble_length = csr_write_data[FEF_PRE_WIDTH-1:0];
            CSR_PREAMBLE_VALUE:  cfg_in.preamble_value  = csr_write_data;
            CSR_START_DELIMITER: cfg_in.start_delimiter = csr_write_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_length <= CSR_PREAMBLE_LENGTH_RESET;
         cfg_ff.preamble_value  <= CSR_PREAMBLE_VALUE_RESET;
         cfg_ff.start_delimiter <= CSR_START_DELIMITER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accept a transaction whenever the command queue has room
   assign full   = q_full;
   assign accept = push && !q_full;

   fef_front #(
      .MAX_FRAME_LENGTH (MAX_FRAME_LENGTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept_i      (accept),
      .data_byte_i   (req_data_byte),
      .frame_start_i (req_frame_start),
      .cmd_push_o    (cmd_push),
      .cmd_o         (cmd)
   );

   fef_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (cmd_push),
      .data_i  (cmd),
      .full_o  (q_full),
      .pop_i   (q_deq),
      .empty_o (q_empty),
      .head_o  (q_head)
   );

   fef_back #(
      .MAX_PREAMBLE (MAX_PREAMBLE)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg_i           (cfg_ff),
      .empty_i         (q_empty),
      .head_i          (q_head),
      .deq_o           (q_deq),
      .rsp_empty_o     (empty),
      .rsp_pop_i       (pop),
      .rsp_out_byte_o  (rsp_out_byte),
      .rsp_dropped_o   (rsp_dropped),
      .rsp_run_last_o  (rsp_run_last),
      .rsp_frame_end_o (rsp_frame_end)
   );

   assert property (@(posedge clock) disable iff (reset)
      full |-> !cmd_push)
      else $error("command issued for a refused transaction");

   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_byte) && $stable(rsp_run_last)))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> accept)
      else $error("command without an accepted transaction");

endmodule

// ----- dv/fef_checker.sv -----
`timescale 1ns / 100ps

module fef_checker
   import fef_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic                      full,
   input  logic [FEF_BYTE_WIDTH-1:0] req_data_byte,
   input  logic                      req_frame_start,
   input  logic                      empty,
   input  logic                      pop,
   input  logic [FEF_BYTE_WIDTH-1:0] rsp_out_byte,
   input  logic                      rsp_dropped,
   input  logic                      rsp_run_last,
   input  logic                      rsp_frame_end,
   input  logic                      csr_write_enable,
   input  logic [FEF_IDX_WIDTH-1:0]  csr_index,
   input  logic [FEF_CSR_WIDTH-1:0]  csr_write_data,
   output int                        mismatch_count,
   output int                        results_due
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [FEF_BYTE_WIDTH-1:0] out_byte;
      logic                      dropped;
      logic                      run_last;
      logic                      frame_end;
   } air_byte_type;

   air_byte_type              air_bytes_due[$];
   cfg_type                   cfg;
   logic                      frame_open;
   logic [FEF_LEFT_WIDTH-1:0] payload_left;
   logic [FEF_FCS_WIDTH-1:0]  fcs_acc;

   function automatic logic [FEF_FCS_WIDTH-1:0] crc16_fold(
      input logic [FEF_FCS_WIDTH-1:0]  crc,
      input logic [FEF_BYTE_WIDTH-1:0] data
   );
      logic [FEF_FCS_WIDTH-1:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ FEF_FCS_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic air_byte_type air_byte(
      input logic [FEF_BYTE_WIDTH-1:0] data,
      input logic                      drop,
      input logic                      fend
   );
      air_byte_type r;
      r.out_byte  = data;
      r.dropped   = drop;
      r.run_last  = 1'b0;
      r.frame_end = fend;
      return r;
   endfunction

   // Expand one accepted frame buffer byte into the on-air bytes it causes.
   task automatic predict_air_bytes(
      input logic [FEF_BYTE_WIDTH-1:0] data,
      input logic                      start
   );
      air_byte_type burst[$];
      int           n_pre;
      logic         close_frame;
      close_frame = 1'b0;
      if (start) begin
         if (data < FEF_MIN_FRAME_LENGTH || data > FEF_MAX_FRAME_LENGTH) begin
            frame_open   = 1'b0;
            payload_left = '0;
            fcs_acc      = '0;
            burst.push_back(air_byte(8'h00, 1'b1, 1'b0));
         end else begin
            n_pre = cfg.preamble_length;
            if (n_pre > FEF_MAX_PREAMBLE) n_pre = FEF_MAX_PREAMBLE;
            repeat (n_pre) burst.push_back(air_byte(cfg.preamble_value, 1'b0, 1'b0));
            burst.push_back(air_byte(cfg.start_delimiter, 1'b0, 1'b0));
            burst.push_back(air_byte(data, 1'b0, 1'b0));
            fcs_acc      = '0;
            payload_left = FEF_LEFT_WIDTH'(data - FEF_MIN_FRAME_LENGTH);
            frame_open   = 1'b1;
            close_frame  = (payload_left == 0);
         end
      end else if (frame_open) begin
         fcs_acc = crc16_fold(fcs_acc, data);
         burst.push_back(air_byte(data, 1'b0, 1'b0));
         payload_left = payload_left - 1'b1;
         close_frame  = (payload_left == 0);
      end
      // FCS goes out low byte first; the high byte closes the frame
      if (close_frame) begin
         burst.push_back(air_byte(fcs_acc[7:0], 1'b0, 1'b0));
         burst.push_back(air_byte(fcs_acc[15:8], 1'b0, 1'b1));
         frame_open   = 1'b0;
         payload_left = '0;
      end
      if (burst.size() > 0) burst[burst.size()-1].run_last = 1'b1;
      foreach (burst[i]) air_bytes_due.push_back(burst[i]);
   endtask

   task automatic note_mismatch(input string what, input air_byte_type want,
                                input air_byte_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t mismatch (%s): expected byte %h dropped %b last %b end %b, got byte %h dropped %b last %b end %b",
                  $realtime, what, want.out_byte, want.dropped, want.run_last,
                  want.frame_end, got.out_byte, got.dropped, got.run_last, got.frame_end);
      end
   endtask

   always @(posedge clock) begin
      air_byte_type got;
      air_byte_type want;
      if (reset) begin
         cfg.preamble_length = CSR_PREAMBLE_LENGTH_RESET;
         cfg.preamble_value  = CSR_PREAMBLE_VALUE_RESET;
         cfg.start_delimiter = CSR_START_DELIMITER_RESET;
         frame_open   = 1'b0;
         payload_left = '0;
         fcs_acc      = '0;
         air_bytes_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PREAMBLE_LENGTH: cfg.preamble_length = csr_write_data[FEF_PRE_WIDTH-1:0];
               CSR_PREAMBLE_VALUE:  cfg.preamble_value  = csr_write_data;
               CSR_START_DELIMITER: cfg.start_delimiter = csr_write_data;
               default: ;
            endcase
         end
         if (push && !full) predict_air_bytes(req_data_byte, req_frame_start);
         if (pop && !empty) begin
            got = {rsp_out_byte, rsp_dropped, rsp_run_last, rsp_frame_end};
            if (air_bytes_due.size() == 0) begin
               note_mismatch("nothing due", 'x, got);
            end else begin
               want = air_bytes_due.pop_front();
               if (got !== want) note_mismatch("wrong field", want, got);
            end
         end
      end
      results_due = air_bytes_due.size();
   end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import fef_pkg::*;

   // Generous ceiling: ~310 items, up to 20 bytes each, pop idle most of the time
   localparam int CYCLE_LIMIT    = 400000;
   // Quiet time after the last result: well above the header burst of the back end
   localparam int SETTLE_CYCLES  = 40;
   localparam int PHASE_ITEMS    = 90;

   logic                      clock;
   logic                      reset;
   logic                      push;
   logic                      pop;
   logic [FEF_BYTE_WIDTH-1:0] req_data_byte;
   logic                      req_frame_start;
   logic                      csr_write_enable;
   logic [FEF_IDX_WIDTH-1:0]  csr_index;
   logic [FEF_CSR_WIDTH-1:0]  csr_write_data;
   logic                      full;
   logic                      empty;
   logic [FEF_BYTE_WIDTH-1:0] rsp_out_byte;
   logic                      rsp_dropped;
   logic                      rsp_run_last;
   logic                      rsp_frame_end;

   int mismatch_count;
   int results_due;
   int tx_idle_pct;
   int rx_idle_pct;
   int cycle_count;
   int sent_items;

   // Opening transactions, {frame_start, byte}, run with the reset settings:
   // a stray byte while waiting, an empty payload, every kind of bad length
   // byte (the first one followed by an ignored byte), the longest length byte,
   // and a frame start that cuts an open frame short before two complete frames.
   localparam logic [8:0] OPENING_SEQ [16] = '{
      {1'b0, 8'h5A}, {1'b1, 8'd2},   {1'b1, 8'd0},   {1'b0, 8'h33},
      {1'b1, 8'd1},  {1'b1, 8'd128}, {1'b1, 8'd255}, {1'b1, 8'd127},
      {1'b0, 8'hFF}, {1'b0, 8'h00},  {1'b1, 8'd5},   {1'b0, 8'hA5},
      {1'b0, 8'h80}, {1'b0, 8'h01},  {1'b1, 8'd3},   {1'b0, 8'h7E}
   };

   ieee802154_frame_emitter dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_data_byte    (req_data_byte),
      .req_frame_start  (req_frame_start),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_dropped      (rsp_dropped),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_end    (rsp_frame_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   fef_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_data_byte    (req_data_byte),
      .req_frame_start  (req_frame_start),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_dropped      (rsp_dropped),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_end    (rsp_frame_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .results_due      (results_due)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count, results_due);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: drop pop for rx_idle_pct percent of the cycles
   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Offer one byte and hold it until the block takes it. Entered and left
   // just after a falling edge; push stays high into the next transaction
   // unless the sender decides to idle.
   task automatic send_byte(input logic [FEF_BYTE_WIDTH-1:0] data, input logic start);
      while ($urandom_range(99) < tx_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push            <= 1'b1;
      req_data_byte   <= data;
      req_frame_start <= start;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   // Send a length byte and the given number of random payload bytes
   task automatic send_frame(input int phr, input int n_payload);
      send_byte(FEF_BYTE_WIDTH'(phr), 1'b1);
      repeat (n_payload) send_byte(FEF_BYTE_WIDTH'($urandom_range(255)), 1'b0);
   endtask

   // Hold the sender off until every predicted byte has been popped
   task automatic wait_results_in();
      push <= 1'b0;
      @(negedge clock);
      while (results_due != 0) @(negedge clock);
   endtask

   // Write all registers with the block idle; the unused index gets noise too
   task automatic load_settings(input logic [FEF_CSR_WIDTH-1:0] len_raw,
                                input logic [FEF_CSR_WIDTH-1:0] value,
                                input logic [FEF_CSR_WIDTH-1:0] delimiter);
      wait_results_in();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_PREAMBLE_LENGTH;
      csr_write_data   <= len_raw;
      @(negedge clock);
      csr_index        <= CSR_PREAMBLE_VALUE;
      csr_write_data   <= value;
      @(negedge clock);
      csr_index        <= CSR_START_DELIMITER;
      csr_write_data   <= delimiter;
      @(negedge clock);
      csr_index        <= ~CSR_PREAMBLE_LENGTH;
      csr_write_data   <= FEF_CSR_WIDTH'($urandom_range(255));
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly complete frames with random content; the rest bad length bytes
   // with ignored trailers and frames cut short by the next frame start.
   // Pause once halfway until the block has drained.
   task automatic random_traffic(input int n_items);
      int   goal;
      int   pick;
      int   phr;
      int   cut;
      logic paused;
      goal   = sent_items + n_items;
      paused = 1'b0;
      while (sent_items < goal) begin
         pick = $urandom_range(99);
         if (pick < 78) begin
            phr = ($urandom_range(59) == 0) ? $urandom_range(13, FEF_MAX_FRAME_LENGTH)
                                            : $urandom_range(2, 12);
            send_frame(phr, phr - 2);
            sent_items += phr - 1;
         end else if (pick < 90) begin
            phr = $urandom_range(1) ? $urandom_range(0, 1) : $urandom_range(128, 255);
            send_byte(FEF_BYTE_WIDTH'(phr), 1'b1);
            sent_items++;
            // ignored bytes: they do not count toward the goal
            repeat ($urandom_range(0, 3)) send_byte(FEF_BYTE_WIDTH'($urandom_range(255)), 1'b0);
         end else begin
            phr = $urandom_range(3, 20);
            cut = $urandom_range(0, phr - 3);
            send_frame(phr, cut);
            sent_items += cut + 1;
         end
         if (!paused && sent_items >= goal - n_items / 2) begin
            wait_results_in();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      logic [FEF_CSR_WIDTH-1:0] len_raw;
      reset            = 1'b1;
      push             = 1'b0;
      req_data_byte    = '0;
      req_frame_start  = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_PREAMBLE_LENGTH;
      csr_write_data   = '0;
      tx_idle_pct      = 19;
      rx_idle_pct      = 82;
      sent_items       = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset register values
      foreach (OPENING_SEQ[i]) send_byte(OPENING_SEQ[i][7:0], OPENING_SEQ[i][8]);

      // No preamble at all, extreme byte values
      load_settings(8'h00, 8'hFF, 8'h00);
      send_frame(2, 0);
      send_byte(8'd3, 1'b1);
      send_byte(8'hC3, 1'b0);

      // Preamble length 31 saturates at the maximum
      load_settings(8'hFF, 8'h55, 8'hFF);
      send_frame(2, 0);
      send_frame(4, 2);

      // Exactly the maximum, upper data bits set but dropped by the register width
      load_settings(8'hF0, 8'hAA, 8'hA7);
      send_frame(2, 0);

      // Random part in three idling phases: sender light / receiver heavy,
      // then swapped, then no idling on either side
      for (int phase = 0; phase < 3; phase++) begin
         len_raw = FEF_CSR_WIDTH'($urandom_range(0, 8)) |
                   (FEF_CSR_WIDTH'($urandom_range(7)) << FEF_PRE_WIDTH);
         load_settings(len_raw, FEF_CSR_WIDTH'($urandom_range(255)),
                       FEF_CSR_WIDTH'($urandom_range(255)));
         tx_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 82 : 0;
         rx_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 19 : 0;
         random_traffic(PHASE_ITEMS);
      end

      // Drain, then give late stray results a chance to show up
      wait_results_in();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && results_due == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
